@@ rtl/odd_prime_generator_trial_division_top_macros.svh @@
// ----------------------------------------------------------------------------
// Assertion macros for the odd prime generator
// Clocked, reset-qualified property wrappers used at the end of the top level.
// ----------------------------------------------------------------------------
`ifndef ODD_PRIME_GENERATOR_TRIAL_DIVISION_TOP_MACROS_SVH
`define ODD_PRIME_GENERATOR_TRIAL_DIVISION_TOP_MACROS_SVH

// Check that a condition holds at every clock edge out of reset
`define OPTD_ASSERT_HOLDS(label, clk, rst, expr, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (expr)) \
      else $error(msg);

// Check that a condition implies another in the same cycle
`define OPTD_ASSERT_IMPLIES(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

`endif

@@ rtl/optd_pkg.sv @@
// ----------------------------------------------------------------------------
// Odd prime generator package
// Widths, table geometry and constants shared by the prime generator.
// ----------------------------------------------------------------------------
`default_nettype none

package optd_pkg;

   // Prime values and the table of found primes
   localparam int VALUE_BITS  = 24;
   localparam int TABLE_DEPTH = 1024;
   localparam int ADDR_BITS   = $clog2(TABLE_DEPTH);
   localparam int COUNT_BITS  = ADDR_BITS + 1;
   // Candidate carries one extra bit to detect running off the value range
   localparam int CAND_BITS   = VALUE_BITS + 1;
   // A divisor at or above 2^HALF_BITS squares past any candidate
   localparam int HALF_BITS   = (VALUE_BITS + 1) / 2;
   localparam int BIT_CNT_BITS = $clog2(VALUE_BITS);

   // Sequence position and limit register
   localparam int INDEX_BITS  = 21;
   localparam int LIMIT_BITS  = 24;
   localparam int LIMIT_CMP_BITS = (VALUE_BITS > LIMIT_BITS) ? VALUE_BITS : LIMIT_BITS;
   localparam logic [LIMIT_BITS-1:0] LIMIT_RESET = LIMIT_BITS'(10000000);

   // Stream payload widths
   localparam int REQ_DATA_BITS = 8;
   localparam int RSP_DATA_BITS = ((VALUE_BITS + INDEX_BITS + 7) / 8) * 8;
   localparam int RSP_USER_BITS = 2;

   localparam logic [VALUE_BITS-1:0] FIRST_PRIME = VALUE_BITS'(3);
   localparam logic [CAND_BITS-1:0]  CAND_STEP   = CAND_BITS'(2);
   localparam logic [COUNT_BITS-1:0] STORED_CAP  = COUNT_BITS'(TABLE_DEPTH);
   localparam logic [INDEX_BITS-1:0] INDEX_MAX   = {INDEX_BITS{1'b1}};

endpackage

`default_nettype wire

@@ rtl/odd_prime_generator_trial_division_top.sv @@
// ----------------------------------------------------------------------------
// Odd prime generator by trial division: one request in flight, reset clears counts, presets limit
// Restart or first request: the result goes from S_DONE into the output register. Next prime:
// each candidate is divided by the stored primes in turn (read, square check, 24-step remainder),
// then stored in S_FOUND; the next request waits until the result is in the output reg.
// ----------------------------------------------------------------------------
`default_nettype none

`include "odd_prime_generator_trial_division_top_macros.svh"

module odd_prime_generator_trial_division_top (
   input  wire logic                                 clock,
   input  wire logic                                 reset,
   // request channel
   input  wire logic                                 req_tvalid,
   output logic                                      req_tready,
   input  wire logic [optd_pkg::REQ_DATA_BITS-1:0]   req_tdata,  // [0] restart, rest zero
   // result channel
   output logic                                      rsp_tvalid,
   input  wire logic                                 rsp_tready,
   output logic [optd_pkg::RSP_DATA_BITS-1:0]        rsp_tdata,  // prime_value, prime_index, zeros
   output logic [optd_pkg::RSP_USER_BITS-1:0]        rsp_tuser,  // past_limit, table_short
   // limit register
   input  wire logic                                 csr_we,
   input  wire logic [optd_pkg::LIMIT_BITS-1:0]      csr_wdata
);

   localparam logic [2:0] S_IDLE  = 3'd0;
   localparam logic [2:0] S_TEST  = 3'd1;
   localparam logic [2:0] S_CHECK = 3'd2;
   localparam logic [2:0] S_DIV   = 3'd3;
   localparam logic [2:0] S_FOUND = 3'd4;
   localparam logic [2:0] S_DONE  = 3'd5;

   localparam int VB = optd_pkg::VALUE_BITS;
   localparam int HB = optd_pkg::HALF_BITS;

   // control state
   logic [2:0]                          state_ff, state_in;
   logic [optd_pkg::LIMIT_BITS-1:0]     max_value_ff, max_value_in;
   logic [VB-1:0]                       last_prime_ff, last_prime_in;
   logic [optd_pkg::INDEX_BITS-1:0]     prime_count_ff, prime_count_in;
   logic [optd_pkg::COUNT_BITS-1:0]     stored_count_ff, stored_count_in;
   logic                                rsp_tvalid_ff, rsp_tvalid_in;

   // search datapath
   logic [optd_pkg::CAND_BITS-1:0]      cand_ff, cand_in;
   logic [optd_pkg::COUNT_BITS-1:0]     idx_ff, idx_in;
   logic [VB-1:0]                       rem_ff, rem_in;
   logic [VB-1:0]                       dvd_ff, dvd_in;
   logic [VB-1:0]                       div_ff, div_in;
   logic [optd_pkg::BIT_CNT_BITS-1:0]   bitcnt_ff, bitcnt_in;

   // pending result and output register
   logic [VB-1:0]                       res_value_ff, res_value_in;
   logic [optd_pkg::INDEX_BITS-1:0]     res_index_ff, res_index_in;
   logic                                res_short_ff, res_short_in;
   logic [VB-1:0]                       rsp_value_ff, rsp_value_in;
   logic [optd_pkg::INDEX_BITS-1:0]     rsp_index_ff, rsp_index_in;
   logic                                rsp_past_ff, rsp_past_in;
   logic                                rsp_short_ff, rsp_short_in;

   // prime table memory
   logic [VB-1:0]                       prime_table_mem [optd_pkg::TABLE_DEPTH];
   logic [VB-1:0]                       rd_data_ff;
   logic                                mem_we;
   logic [optd_pkg::ADDR_BITS-1:0]      mem_waddr;
   logic [VB-1:0]                       mem_wdata;

   // combinational helpers
   logic                                req_fire;
   logic                                restart;
   logic [optd_pkg::CAND_BITS-1:0]      first_cand;
   logic [optd_pkg::CAND_BITS-1:0]      next_cand;
   logic [HB-1:0]                       p_lo;
   logic                                p_big;
   logic [2*HB-1:0]                     p_sq;
   logic                                sq_over;
   logic [VB:0]                         rem_shift;
   logic [VB:0]                         rem_diff;
   logic [VB-1:0]                       rem_next;
   logic                                div_last;
   logic                                out_free;

   assign req_tready = (state_ff == S_IDLE);
   assign req_fire   = req_tvalid && req_tready;
   assign restart    = req_tdata[0];
   assign first_cand = {1'b0, last_prime_ff} + optd_pkg::CAND_STEP;
   assign next_cand  = cand_ff + optd_pkg::CAND_STEP;
   assign out_free   = !rsp_tvalid_ff || rsp_tready;

   // Square check on the table entry; large divisors always exceed the root
   assign p_lo    = rd_data_ff[HB-1:0];
   assign p_big   = (rd_data_ff[VB-1:HB] != '0);
   assign p_sq    = p_lo * p_lo;
   assign sq_over = p_big || (optd_pkg::CAND_BITS'(p_sq) > cand_ff);

   // One restoring remainder step per cycle
   assign rem_shift = {rem_ff, dvd_ff[VB-1]};
   assign rem_diff  = rem_shift - {1'b0, div_ff};
   assign rem_next  = (rem_shift >= {1'b0, div_ff}) ? rem_diff[VB-1:0] : rem_shift[VB-1:0];
   assign div_last  = (bitcnt_ff == optd_pkg::BIT_CNT_BITS'(VB - 1));

   // Sequencer: candidate search, table update and result hand-off
   always_comb begin
      state_in        = state_ff;
      max_value_in    = csr_we ? csr_wdata : max_value_ff;
      last_prime_in   = last_prime_ff;
      prime_count_in  = prime_count_ff;
      stored_count_in = stored_count_ff;
      rsp_tvalid_in   = rsp_tvalid_ff && !rsp_tready;
      cand_in         = cand_ff;
      idx_in          = idx_ff;
      rem_in          = rem_ff;
      dvd_in          = dvd_ff;
      div_in          = div_ff;
      bitcnt_in       = bitcnt_ff;
      res_value_in    = res_value_ff;
      res_index_in    = res_index_ff;
      res_short_in    = res_short_ff;
      rsp_value_in    = rsp_value_ff;
      rsp_index_in    = rsp_index_ff;
      rsp_past_in     = rsp_past_ff;
      rsp_short_in    = rsp_short_ff;
      mem_we          = 1'b0;
      mem_waddr       = '0;
      mem_wdata       = optd_pkg::FIRST_PRIME;

      unique case (state_ff)
         S_IDLE: begin
            if (req_fire) begin
               if (restart || (last_prime_ff == '0)) begin
                  // start over: table holds only the first prime
                  mem_we          = 1'b1;
                  stored_count_in = optd_pkg::COUNT_BITS'(1);
                  last_prime_in   = optd_pkg::FIRST_PRIME;
                  prime_count_in  = optd_pkg::INDEX_BITS'(1);
                  res_value_in    = optd_pkg::FIRST_PRIME;
                  res_index_in    = '0;
                  res_short_in    = 1'b0;
                  state_in        = S_DONE;
               end else if (first_cand[VB]) begin
                  // out of range: repeat the last prime, state unchanged
                  res_value_in = last_prime_ff;
                  res_index_in = prime_count_ff - optd_pkg::INDEX_BITS'(1);
                  res_short_in = 1'b0;
                  state_in     = S_DONE;
               end else begin
                  cand_in  = first_cand;
                  idx_in   = '0;
                  state_in = S_TEST;
               end
            end
         end
         S_TEST: begin
            // table exhausted before covering the root: accept, flag short
            if (idx_ff >= stored_count_ff) begin
               res_short_in = 1'b1;
               state_in     = S_FOUND;
            end else begin
               state_in = S_CHECK;
            end
         end
         S_CHECK: begin
            if ((rd_data_ff == '0) || sq_over) begin
               res_short_in = 1'b0;
               state_in     = S_FOUND;
            end else begin
               rem_in    = '0;
               dvd_in    = cand_ff[VB-1:0];
               div_in    = rd_data_ff;
               bitcnt_in = '0;
               state_in  = S_DIV;
            end
         end
         S_DIV: begin
            rem_in    = rem_next;
            dvd_in    = {dvd_ff[VB-2:0], 1'b0};
            bitcnt_in = bitcnt_ff + optd_pkg::BIT_CNT_BITS'(1);
            if (div_last) begin
               if (rem_next == '0) begin
                  // composite: advance to the next odd candidate, or repeat the last prime past the range
                  if (next_cand[VB]) begin
                     res_value_in = last_prime_ff;
                     res_index_in = prime_count_ff - optd_pkg::INDEX_BITS'(1);
                     res_short_in = 1'b0;
                     state_in     = S_DONE;
                  end else begin
                     cand_in  = next_cand;
                     idx_in   = '0;
                     state_in = S_TEST;
                  end
               end else begin
                  idx_in   = idx_ff + optd_pkg::COUNT_BITS'(1);
                  state_in = S_TEST;
               end
            end
         end
         S_FOUND: begin
            // append while there is room, count with saturation
            if (stored_count_ff < optd_pkg::STORED_CAP) begin
               mem_we          = 1'b1;
               stored_count_in = stored_count_ff + optd_pkg::COUNT_BITS'(1);
            end
            mem_waddr     = stored_count_ff[optd_pkg::ADDR_BITS-1:0];
            mem_wdata     = cand_ff[VB-1:0];
            last_prime_in = cand_ff[VB-1:0];
            res_value_in  = cand_ff[VB-1:0];
            res_index_in  = prime_count_ff;
            if (prime_count_ff != optd_pkg::INDEX_MAX) begin
               prime_count_in = prime_count_ff + optd_pkg::INDEX_BITS'(1);
            end
            state_in = S_DONE;
         end
         S_DONE: begin
            // hand the result to the output register once it is free
            if (out_free) begin
               rsp_tvalid_in = 1'b1;
               rsp_value_in  = res_value_ff;
               rsp_index_in  = res_index_ff;
               rsp_short_in  = res_short_ff;
               rsp_past_in   = optd_pkg::LIMIT_CMP_BITS'(res_value_ff) >
                               optd_pkg::LIMIT_CMP_BITS'(max_value_ff);
               state_in      = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   // Control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff        <= S_IDLE;
         max_value_ff    <= optd_pkg::LIMIT_RESET;
         last_prime_ff   <= '0;
         prime_count_ff  <= '0;
         stored_count_ff <= '0;
         rsp_tvalid_ff   <= 1'b0;
      end else begin
         state_ff        <= state_in;
         max_value_ff    <= max_value_in;
         last_prime_ff   <= last_prime_in;
         prime_count_ff  <= prime_count_in;
         stored_count_ff <= stored_count_in;
         rsp_tvalid_ff   <= rsp_tvalid_in;
      end
   end

   // Payload registers
   always_ff @(posedge clock) begin
      cand_ff      <= cand_in;
      idx_ff       <= idx_in;
      rem_ff       <= rem_in;
      dvd_ff       <= dvd_in;
      div_ff       <= div_in;
      bitcnt_ff    <= bitcnt_in;
      res_value_ff <= res_value_in;
      res_index_ff <= res_index_in;
      res_short_ff <= res_short_in;
      rsp_value_ff <= rsp_value_in;
      rsp_index_ff <= rsp_index_in;
      rsp_past_ff  <= rsp_past_in;
      rsp_short_ff <= rsp_short_in;
   end

   // Prime table: one write port, one registered read port
   always_ff @(posedge clock) begin
      if (mem_we) begin
         prime_table_mem[mem_waddr] <= mem_wdata;
      end
      rd_data_ff <= prime_table_mem[idx_ff[optd_pkg::ADDR_BITS-1:0]];
   end

   assign rsp_tvalid = rsp_tvalid_ff;
   assign rsp_tdata  = optd_pkg::RSP_DATA_BITS'({rsp_index_ff, rsp_value_ff});
   assign rsp_tuser  = {rsp_short_ff, rsp_past_ff};

   // Assertions
   `OPTD_ASSERT_HOLDS(a_stored_bound, clock, reset, stored_count_ff <= optd_pkg::STORED_CAP, "stored count past table depth")
   `OPTD_ASSERT_IMPLIES(a_idx_bound, clock, reset, (state_ff == S_CHECK) || (state_ff == S_DIV), idx_ff < stored_count_ff, "table read beyond stored primes")
   `OPTD_ASSERT_IMPLIES(a_odd_result, clock, reset, $rose(rsp_tvalid_ff), rsp_value_ff[0], "even value presented as prime")
   `OPTD_ASSERT_IMPLIES(a_count_tracks, clock, reset, last_prime_ff != '0, prime_count_ff != '0, "prime held with zero count")

endmodule

`default_nettype wire

@@ tb/tb_odd_prime_generator_trial_division_top.sv @@
// ----------------------------------------------------------------------------
// Odd prime generator testbench
// Streams next-prime and restart requests into the generator and compares
// every result with a prime sequence tracker that keeps its own table of
// found primes. Random idling on both sides and a long receiver hold-off.
// ----------------------------------------------------------------------------
module tb_odd_prime_generator_trial_division_top;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int VBITS = optd_pkg::VALUE_BITS;
   localparam int IBITS = optd_pkg::INDEX_BITS;
   localparam int LBITS = optd_pkg::LIMIT_BITS;
   localparam int DEPTH = optd_pkg::TABLE_DEPTH;
   localparam longint unsigned VALUE_TOP = (64'd1 << VBITS) - 1;
   localparam longint unsigned INDEX_TOP = (64'd1 << IBITS) - 1;
   localparam bit NEXT_PRIME = 1'b0;
   localparam bit RESTART    = 1'b1;

   typedef struct packed {
      logic [VBITS-1:0] value;
      logic [IBITS-1:0] index;
      logic             past_limit;
      logic             table_short;
   } prime_result_t;

   // Tracks the prime sequence and holds the results still owed by the block
   class prime_sequence_tracker;
      logic [VBITS-1:0] found_primes [DEPTH];
      longint unsigned  last_prime;
      longint unsigned  prime_total;
      int unsigned      stored_total;
      longint unsigned  limit;
      prime_result_t    owed_primes [$];
      int unsigned      failures;

      function new();
         last_prime   = 0;
         prime_total  = 0;
         stored_total = 0;
         limit        = optd_pkg::LIMIT_RESET;
         failures     = 0;
      endfunction

      function void store_prime(longint unsigned p);
         if (stored_total < DEPTH) begin
            found_primes[stored_total] = p[VBITS-1:0];
            stored_total++;
         end
      endfunction

      // Work out the result of one accepted request and queue it
      function void note_request(bit restart);
         prime_result_t   r;
         longint unsigned cand;
         longint unsigned p;
         bit              found;
         bit              is_prime;
         bit              ran_short;
         int unsigned     i;
         r = '0;
         ran_short = 1'b0;
         if (restart || last_prime == 0) begin
            stored_total = 0;
            store_prime(3);
            last_prime  = 3;
            prime_total = 1;
            r.value = VBITS'(3);
            r.index = '0;
         end else begin
            cand  = last_prime + 2;
            found = 1'b0;
            while (!found && cand <= VALUE_TOP) begin
               is_prime  = 1'b1;
               ran_short = 1'b1;
               for (i = 0; i < stored_total; i++) begin
                  p = found_primes[i];
                  if (p * p > cand) begin
                     ran_short = 1'b0;
                     break;
                  end
                  if (cand % p == 0) begin
                     is_prime  = 1'b0;
                     ran_short = 1'b0;
                     break;
                  end
               end
               if (is_prime) found = 1'b1;
               else cand += 2;
            end
            if (found) begin
               store_prime(cand);
               last_prime = cand;
               r.value = cand[VBITS-1:0];
               r.index = prime_total[IBITS-1:0];
               r.table_short = ran_short;
               if (prime_total < INDEX_TOP) prime_total++;
            end else begin
               // sequence end: repeat the last prime, state unchanged
               r.value = last_prime[VBITS-1:0];
               r.index = (prime_total > 0) ? IBITS'(prime_total - 1) : '0;
               r.table_short = 1'b0;
            end
         end
         r.past_limit = (longint'(r.value) > limit);
         owed_primes = {owed_primes, r};
      endfunction

      function void report(string what, prime_result_t e, prime_result_t a);
         failures++;
         if (failures <= 10)
            $display("%0t: %s: expected value %0d index %0d past %0b short %0b,",
                     $realtime, what, e.value, e.index, e.past_limit, e.table_short,
                     " got value %0d index %0d past %0b short %0b",
                     a.value, a.index, a.past_limit, a.table_short);
      endfunction

      // Compare one accepted result with the oldest owed prime
      function void check_result(prime_result_t a);
         prime_result_t e;
         if (owed_primes.size() == 0) begin
            report("result with no request pending", '0, a);
            return;
         end
         e = owed_primes.pop_front();
         if (a.value !== e.value || a.index !== e.index ||
             a.past_limit !== e.past_limit || a.table_short !== e.table_short)
            report("prime mismatch", e, a);
      endfunction

      function int unsigned pending();
         return owed_primes.size();
      endfunction
   endclass

   logic clock = 1'b0;
   logic reset;
   logic req_tvalid;
   logic req_tready;
   logic [optd_pkg::REQ_DATA_BITS-1:0] req_tdata;   // [0] restart, rest zero
   logic rsp_tvalid;
   logic rsp_tready;
   logic [optd_pkg::RSP_DATA_BITS-1:0] rsp_tdata;   // prime_value, prime_index, zeros
   logic [optd_pkg::RSP_USER_BITS-1:0] rsp_tuser;   // past_limit, table_short
   logic csr_we;
   logic [LBITS-1:0] csr_wdata;

   prime_sequence_tracker primes;
   int unsigned send_idle_pct = 0;
   int unsigned recv_idle_pct = 0;
   int unsigned ready_hold    = 0;

   odd_prime_generator_trial_division_top dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .csr_we     (csr_we),
      .csr_wdata  (csr_wdata)
   );

   always begin
      #6 clock = 1'b1;
      #6 clock = 1'b0;
   end

   // Drive result ready: long hold-off first, else random idling
   initial begin
      rsp_tready = 1'b0;
      forever begin
         @(negedge clock);
         if (ready_hold > 0) begin
            rsp_tready <= 1'b0;
            ready_hold--;
         end else begin
            rsp_tready <= ($urandom_range(0, 99) >= recv_idle_pct);
         end
      end
   end

   // Check every accepted result
   initial begin
      prime_result_t got;
      forever begin
         @(posedge clock);
         if (!reset && rsp_tvalid && rsp_tready) begin
            got.value       = rsp_tdata[VBITS-1:0];
            got.index       = rsp_tdata[VBITS +: IBITS];
            got.past_limit  = rsp_tuser[0];
            got.table_short = rsp_tuser[1];
            primes.check_result(got);
         end
      end
   end

   // Offer one request, with a random gap first; leave valid high afterwards
   task automatic send_request(input bit restart);
      while ($urandom_range(0, 99) < send_idle_pct) begin
         req_tvalid <= 1'b0;
         @(negedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= optd_pkg::REQ_DATA_BITS'(restart);
      do @(posedge clock); while (!req_tready);
      primes.note_request(restart);
      @(negedge clock);
   endtask

   // Drop valid and wait until every owed prime has come back
   task automatic drain_results();
      req_tvalid <= 1'b0;
      while (primes.pending() != 0) @(posedge clock);
      @(negedge clock);
   endtask

   // Write the limit register while the block is idle
   task automatic write_limit(input logic [LBITS-1:0] v);
      csr_we    <= 1'b1;
      csr_wdata <= v;
      @(posedge clock);
      primes.limit = v;
      @(negedge clock);
      csr_we <= 1'b0;
   endtask

   task automatic random_requests(input int count);
      for (int k = 0; k < count; k++)
         send_request(($urandom_range(0, 63) == 0) ? RESTART : NEXT_PRIME);
   endtask

   initial begin
      primes = new();
      reset      <= 1'b1;
      req_tvalid <= 1'b0;
      req_tdata  <= '0;
      csr_we     <= 1'b0;
      csr_wdata  <= '0;
      repeat (9) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // first request after reset without restart, then restarts mid-sequence
      send_request(NEXT_PRIME);
      repeat (5) send_request(NEXT_PRIME);
      send_request(RESTART);
      send_request(RESTART);
      repeat (6) send_request(NEXT_PRIME);
      drain_results();

      // lowest limit: 3 and 5 pass, 7 and up flagged
      write_limit(LBITS'(5));
      send_request(RESTART);
      repeat (4) send_request(NEXT_PRIME);
      send_request(RESTART);
      send_request(NEXT_PRIME);
      send_request(NEXT_PRIME);

      // sender sparse-ish, receiver mostly stalled
      send_idle_pct = 24;
      recv_idle_pct = 71;
      random_requests(80);
      drain_results();

      // highest limit, idling the other way round, with a full pause midway
      write_limit({LBITS{1'b1}});
      send_idle_pct = 71;
      recv_idle_pct = 24;
      random_requests(40);
      drain_results();
      random_requests(40);
      drain_results();

      // no idling; hold the receiver off so the block backs up
      write_limit(LBITS'($urandom_range(5, 400)));
      send_idle_pct = 0;
      recv_idle_pct = 0;
      ready_hold = 3000;
      repeat (10) send_request(NEXT_PRIME);
      random_requests(80);
      drain_results();

      // a short run from a fresh start, then start over
      write_limit(LBITS'($urandom_range(3000, 6000)));
      send_request(RESTART);
      repeat (10) send_request(NEXT_PRIME);
      send_request(RESTART);
      repeat (4) send_request(NEXT_PRIME);
      drain_results();

      repeat (40) @(posedge clock);
      if (primes.failures == 0 && primes.pending() == 0) begin
         $display("tb_odd_prime_generator_trial_division_top OK");
      end else begin
         $display("tb_odd_prime_generator_trial_division_top NOT OK");
      end
      $finish;
   end

   // Stop a hung run
   initial begin
      #(64'd250_000_000);
      $display("tb_odd_prime_generator_trial_division_top NOT OK");
      $finish;
   end

endmodule
